// ===== sv/rtpg_pkg.sv =====
// Shared types, constants and helpers for the raster test pattern generator.
// Used by every rtpg_* module and by the top level; no dependencies.
package rtpg_pkg;

	localparam int MAX_SIZE_DEF = 512;

	localparam int PIX_W   = 8;  // color component width, also quotient width
	localparam int COORD_W = 9;  // column/row port width
	localparam int SIZE_W  = 10; // image_size register width
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [DATA_W-1:0] RNG_DEFAULT = 32'd42;
	localparam int RNG_SH_A = 13;
	localparam int RNG_SH_B = 17;
	localparam int RNG_SH_C = 5;
	localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

	// Register index = paddr[3:2]
	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_SIZE    = 2'd1;
	localparam logic [1:0] REG_SEED    = 2'd2;

	typedef enum logic [1:0] {
		PAT_GRADIENT = 2'd0,
		PAT_CHECKER  = 2'd1,
		PAT_RANDOM   = 2'd2,
		PAT_BLANK    = 2'd3
	} pattern_t;

	typedef struct packed {
		pattern_t             pattern;
		logic [SIZE_W-1:0]    image_size;
		logic [DATA_W-1:0]    seed;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_WRITE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;     // input transfer this cycle
		logic div_step; // one quotient bit on both divider lanes
		logic out_load; // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div; // current pattern is gradient
		logic out_free; // output register can be loaded this cycle
	} sts_t;

	function automatic logic [DATA_W-1:0] xorshift32(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		t = v ^ (v << RNG_SH_A);
		t = t ^ (t >> RNG_SH_B);
		t = t ^ (t << RNG_SH_C);
		return t;
	endfunction

endpackage

// ===== sv/raster_test_pattern_generator_core.sv =====
// Raster test pattern generator, top level.
// Depends on rtpg_pkg, rtpg_regs, rtpg_ctrl, rtpg_dpath, rtpg_div.
//
// Usage:
// - APB port sets pattern (addr 0), image_size (addr 4) and seed (addr 8);
//   pready is tied high. Write registers only while no request is in flight.
// - Each request transfer (request_valid/request_ready) yields exactly one
//   pixel transfer (pixel_valid/pixel_ready) in row-major order. restart=1
//   begins a new frame at 0,0 and reloads the generator from seed.
// - Sequence per request: gradient loads the divider lanes at the accept
//   edge, runs eight divide steps on two parallel radix-2 lanes, then one
//   write; checker, random and blank go from accept straight to the write.
//   A new request can be accepted in the cycle after the write, so no request
//   is taken before the previous pixel is loaded into the output register.
// - The output register decouples the two sides: the next request is taken
//   and computed while the previous pixel waits. If the receiver stalls, the
//   finished pixel is held in the write state until the output frees up.
// - Reset: registers return to gradient, 512x512, seed 0; the first request
//   opens a new frame. pixel_valid drops, nothing is pending.
module raster_test_pattern_generator_core
	import rtpg_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// request channel
	input  logic               request_valid,
	output logic               request_ready,
	input  logic               restart,
	// pixel channel
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output logic [PIX_W-1:0]   red,
	output logic [PIX_W-1:0]   green,
	output logic [PIX_W-1:0]   blue,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row,
	output logic               last_pixel
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	rtpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencing: idle -> (divide) -> write
	rtpg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.sts           (sts),
		.cmd           (cmd)
	);

	// counters, generator, dividers and output register
	rtpg_dpath #(.MAX_SIZE(MAX_SIZE)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.restart     (restart),
		.pixel_ready (pixel_ready),
		.pixel_valid (pixel_valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.column      (column),
		.row         (row),
		.last_pixel  (last_pixel)
	);

endmodule

// ===== sv/rtpg_regs.sv =====
// APB configuration registers: pattern, image_size, seed.
// Depends on rtpg_pkg.
module rtpg_regs
	import rtpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern    <= PAT_GRADIENT;
			cfg_q.image_size <= SIZE_W'(512);
			cfg_q.seed       <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_PATTERN: cfg_q.pattern    <= pattern_t'(pwdata[1:0]);
				REG_SIZE:    cfg_q.image_size <= pwdata[SIZE_W-1:0];
				REG_SEED:    cfg_q.seed       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PATTERN: prdata = DATA_W'(cfg_q.pattern);
			REG_SIZE:    prdata = DATA_W'(cfg_q.image_size);
			REG_SEED:    prdata = cfg_q.seed;
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/rtpg_div.sv =====
// Restoring radix-2 divider lane, one quotient bit per step, PIX_W steps.
// Quotient must fit PIX_W bits (numer < divisor << PIX_W). Depends on rtpg_pkg.
module rtpg_div
	import rtpg_pkg::*;
#(
	parameter int CW = 9
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic                  step,
	input  logic [CW+PIX_W-1:0]   numer,
	input  logic [CW-1:0]         divisor,
	output logic [PIX_W-1:0]      quot
);

	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    div_q;
	logic [PIX_W-1:0] quot_q; // low numerator bits shift out, quotient bits shift in
	logic [CW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quot_q[PIX_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= numer[CW+PIX_W-1:PIX_W];
			quot_q <= numer[PIX_W-1:0];
			div_q  <= divisor;
		end else if (step) begin
			rem_q  <= fits ? CW'(trial - {1'b0, div_q}) : CW'(trial);
			quot_q <= {quot_q[PIX_W-2:0], fits};
		end
	end

	assign quot = quot_q;

endmodule

// ===== sv/rtpg_dpath.sv =====
// Datapath: raster counters, xorshift32 generator, two divider lanes
// for the gradient and the output register. Depends on rtpg_pkg, rtpg_div.
module rtpg_dpath
	import rtpg_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               restart,
	input  logic               pixel_ready,
	output logic               pixel_valid,
	output logic [PIX_W-1:0]   red,
	output logic [PIX_W-1:0]   green,
	output logic [PIX_W-1:0]   blue,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row,
	output logic               last_pixel
);

	localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;  // counter width
	localparam int SW = $clog2(MAX_SIZE + 1);                     // side width
	localparam int LW = (SW > SIZE_W) ? SW : SIZE_W;
	localparam int NW = CW + PIX_W;

	logic [CW-1:0]      col_q, row_q;
	logic               frame_open_q;
	logic [DATA_W-1:0]  rng_q;

	logic [CW-1:0]      x_q, y_q;
	logic               last_q, grad_q;
	logic [PIX_W-1:0]   red_q, green_q, blue_q;

	logic               out_valid_q;
	logic [PIX_W-1:0]   red_out_q, green_out_q, blue_out_q;
	logic [COORD_W-1:0] col_out_q, row_out_q;
	logic               last_out_q;

	logic [LW-1:0]      size_ext, side_l;
	logic [SW-1:0]      side;
	logic [CW-1:0]      side_m1, divisor, x, y, g_span;
	logic               frame_start, last;
	logic [DATA_W-1:0]  rng_base, rnd1, rnd2, rnd3;
	logic [NW-1:0]      numer_r, numer_g;
	logic [PIX_W-1:0]   quot_r, quot_g, chk;

	always_comb begin
		size_ext = LW'(cfg.image_size);
		if (size_ext == '0) begin
			side_l = LW'(1);
		end else if (size_ext > LW'(MAX_SIZE)) begin
			side_l = LW'(MAX_SIZE);
		end else begin
			side_l = size_ext;
		end
		side    = SW'(side_l);
		side_m1 = CW'(side - SW'(1));
		divisor = (side == SW'(1)) ? CW'(1) : side_m1;

		// frame restarts on request, after a finished frame, or when size shrank
		frame_start = restart | ~frame_open_q
			| (SW'(col_q) >= side) | (SW'(row_q) >= side);
		x = frame_start ? '0 : col_q;
		y = frame_start ? '0 : row_q;
		last = (x == side_m1) && (y == side_m1);

		rng_base = frame_start ? ((cfg.seed == '0) ? RNG_DEFAULT : cfg.seed) : rng_q;
		rnd1 = xorshift32(rng_base);
		rnd2 = xorshift32(rnd1);
		rnd3 = xorshift32(rnd2);

		// v*255 = (v << 8) - v
		g_span  = divisor - y;
		numer_r = {x, {PIX_W{1'b0}}} - NW'(x);
		numer_g = {g_span, {PIX_W{1'b0}}} - NW'(g_span);

		chk = (x[0] ^ y[0]) ? '0 : PIX_FULL;
	end

	rtpg_div #(.CW(CW)) u_div_red (
		.clk     (clk),
		.load    (cmd.take),
		.step    (cmd.div_step),
		.numer   (numer_r),
		.divisor (divisor),
		.quot    (quot_r)
	);

	rtpg_div #(.CW(CW)) u_div_green (
		.clk     (clk),
		.load    (cmd.take),
		.step    (cmd.div_step),
		.numer   (numer_g),
		.divisor (divisor),
		.quot    (quot_g)
	);

	// raster position and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			frame_open_q <= 1'b0;
			rng_q        <= RNG_DEFAULT;
		end else if (cmd.take) begin
			rng_q <= (cfg.pattern == PAT_RANDOM) ? rnd3 : rng_base;
			if (last) begin
				col_q        <= '0;
				row_q        <= '0;
				frame_open_q <= 1'b0;
			end else if (x == side_m1) begin
				col_q        <= '0;
				row_q        <= y + CW'(1);
				frame_open_q <= 1'b1;
			end else begin
				col_q        <= x + CW'(1);
				row_q        <= y;
				frame_open_q <= 1'b1;
			end
		end
	end

	// item held while the dividers run
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q    <= x;
			y_q    <= y;
			last_q <= last;
			grad_q <= (cfg.pattern == PAT_GRADIENT);
			unique case (cfg.pattern)
				PAT_CHECKER: begin
					red_q   <= chk;
					green_q <= chk;
					blue_q  <= chk;
				end
				PAT_RANDOM: begin
					red_q   <= rnd1[PIX_W-1:0];
					green_q <= rnd2[PIX_W-1:0];
					blue_q  <= rnd3[PIX_W-1:0];
				end
				default: begin
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (pixel_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out_q   <= grad_q ? quot_r : red_q;
			green_out_q <= grad_q ? quot_g : green_q;
			blue_out_q  <= blue_q;
			col_out_q   <= COORD_W'(x_q);
			row_out_q   <= COORD_W'(y_q);
			last_out_q  <= last_q;
		end
	end

	assign sts.need_div = (cfg.pattern == PAT_GRADIENT);
	assign sts.out_free = ~out_valid_q | pixel_ready;

	assign pixel_valid = out_valid_q;
	assign red         = red_out_q;
	assign green       = green_out_q;
	assign blue        = blue_out_q;
	assign column      = col_out_q;
	assign row         = row_out_q;
	assign last_pixel  = last_out_q;

endmodule

// ===== sv/rtpg_ctrl.sv =====
// Controller FSM: accept, PIX_W divide steps for gradient, write to output.
// Depends on rtpg_pkg.
module rtpg_ctrl
	import rtpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic request_valid,
	output logic request_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int STEP_W = $clog2(PIX_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PIX_W - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVIDE) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (request_valid) begin
					state_d = sts.need_div ? ST_DIVIDE : ST_WRITE;
				end
			end
			ST_DIVIDE: begin
				if (step_q == STEP_LAST) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		request_ready = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				request_ready = 1'b1;
				cmd.take      = request_valid;
			end
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_WRITE:  cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== dv/raster_test_pattern_generator_core_test.sv =====
// Self-checking testbench for raster_test_pattern_generator_core.
// Needs rtpg_pkg and the core RTL; drives APB, request and pixel channels, predicts each pixel.
module raster_test_pattern_generator_core_test;
	import rtpg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Expected pixel, at the widths of the pixel ports
	typedef struct {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               request_valid = 1'b0;
	logic               request_ready;
	logic               restart = 1'b0;
	logic               pixel_valid;
	logic               pixel_ready = 1'b0;
	logic [PIX_W-1:0]   red;
	logic [PIX_W-1:0]   green;
	logic [PIX_W-1:0]   blue;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic               last_pixel;

	raster_test_pattern_generator_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.request_valid(request_valid), .request_ready(request_ready), .restart(restart),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
		.red(red), .green(green), .blue(blue),
		.column(column), .row(row), .last_pixel(last_pixel)
	);

	always #5 clk = ~clk;

	// Register mirror, same values as after reset of the core
	pattern_t          cfg_pattern = PAT_GRADIENT;
	logic [SIZE_W-1:0] cfg_size = SIZE_W'(512);
	logic [DATA_W-1:0] cfg_seed = '0;

	// Predictor state: position of the next pixel, generator, frame flag
	int unsigned       col_next = 0;
	int unsigned       row_next = 0;
	logic [DATA_W-1:0] lfsr = RNG_DEFAULT;
	bit                open_frame = 1'b0;

	logic   pend_restart[$];  // request transfers still to be driven
	pixel_t pixels_due[$];    // predicted pixels not yet seen

	int errors = 0;
	int n_taken = 0;          // accepted request transfers
	int n_checked = 0;
	int n_frames = 0;
	int per_pattern[4] = '{0, 0, 0, 0};

	// A stretch of transfers where neither side idles
	wire quiet = (n_taken >= 250) && (n_taken < 400);

	function automatic logic [DATA_W-1:0] xs_next(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		t = v ^ (v << 13);
		t = t ^ (t >> 17);
		return t ^ (t << 5);
	endfunction

	// Work out the pixel that one accepted request produces and advance the raster
	task automatic predict_pixel(input logic rs);
		int unsigned s, m, x, y;
		pixel_t p;
		s = (cfg_size == 0) ? 1 : ((cfg_size > MAX_SIZE_DEF) ? MAX_SIZE_DEF : cfg_size);
		m = (s == 1) ? 1 : s - 1;
		// frame start: restart, closed frame, or position past a shrunk size
		if (rs || !open_frame || col_next >= s || row_next >= s) begin
			col_next = 0;
			row_next = 0;
			lfsr = (cfg_seed != 0) ? cfg_seed : RNG_DEFAULT;
			open_frame = 1'b1;
		end
		x = col_next;
		y = row_next;
		p.red = '0;
		p.green = '0;
		p.blue = '0;
		case (cfg_pattern)
			PAT_GRADIENT: begin
				p.red = PIX_W'((x * 255) / m);
				p.green = PIX_W'(((m - y) * 255) / m);
			end
			PAT_CHECKER: begin
				p.red = ((x + y) % 2 == 0) ? PIX_FULL : '0;
				p.green = p.red;
				p.blue = p.red;
			end
			PAT_RANDOM: begin
				lfsr = xs_next(lfsr);
				p.red = lfsr[PIX_W-1:0];
				lfsr = xs_next(lfsr);
				p.green = lfsr[PIX_W-1:0];
				lfsr = xs_next(lfsr);
				p.blue = lfsr[PIX_W-1:0];
			end
			default: ;  // blank: black, generator holds
		endcase
		p.column = COORD_W'(x);
		p.row = COORD_W'(y);
		p.last = (x == s - 1) && (y == s - 1);
		if (p.last) begin
			open_frame = 1'b0;
			col_next = 0;
			row_next = 0;
		end else if (x + 1 >= s) begin
			col_next = 0;
			row_next = y + 1;
		end else begin
			col_next = x + 1;
		end
		per_pattern[cfg_pattern]++;
		pixels_due.push_back(p);
	endtask

	// Request driver: one transfer per queued restart bit, random idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_valid <= 1'b0;
			restart <= 1'b0;
			n_taken <= 0;
		end else begin
			if (request_valid && request_ready) begin
				predict_pixel(restart);
				n_taken <= n_taken + 1;
			end
			if (!request_valid || request_ready) begin
				if (pend_restart.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
					request_valid <= 1'b1;
					restart <= pend_restart.pop_front();
				end else begin
					request_valid <= 1'b0;
					restart <= 1'($urandom_range(1));  // noise while no transfer is offered
				end
			end
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Pixel monitor: compare each pixel transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : pixel_mon
		pixel_t want;
		if (!arst_n) begin
			pixel_ready <= 1'b0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				if (pixels_due.size() == 0) begin
					$error("pixel transfer with no pixel expected");
					errors++;
				end else begin
					want = pixels_due.pop_front();
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("column", want.column, column);
					check_field("row", want.row, row);
					check_field("last_pixel", want.last, last_pixel);
					n_checked++;
					if (want.last)
						n_frames++;
				end
			end
			pixel_ready <= quiet || ($urandom_range(99) >= 9);
		end
	end

	// APB write: setup cycle, access cycle; register is written at the access edge
	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PATTERN: cfg_pattern = pattern_t'(data[1:0]);
			REG_SIZE:    cfg_size = data[SIZE_W-1:0];
			default:     cfg_seed = data;
		endcase
	endtask

	task automatic queue_requests(input int count, input logic rs_first);
		for (int i = 0; i < count; i++)
			pend_restart.push_back((i == 0) ? rs_first : 1'b0);
	endtask

	// Wait until every queued transfer went out and every pixel came back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pend_restart.size() != 0 || request_valid || pixels_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int rand_items;
		int burst;
		int pick;
		logic [DATA_W-1:0] size_word;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: gradient 512x512, seed 0, first request opens a frame
		pend_restart.push_back(1'b0);
		pend_restart.push_back(1'b0);
		pend_restart.push_back(1'b1);
		pend_restart.push_back(1'b0);
		wait_idle();

		// Blank pattern code: black pixels, counters still move
		reg_write(REG_PATTERN, DATA_W'(PAT_BLANK));
		queue_requests(2, 1'b0);
		wait_idle();

		// One-pixel image: every pixel is the last, divisor forced to one
		reg_write(REG_PATTERN, DATA_W'(PAT_GRADIENT));
		reg_write(REG_SIZE, 32'd1);
		queue_requests(2, 1'b0);
		wait_idle();
		// size zero behaves as one
		reg_write(REG_SIZE, 32'd0);
		queue_requests(1, 1'b0);
		wait_idle();

		// Checker 2x2: whole frame, then the next request starts a new one
		reg_write(REG_PATTERN, DATA_W'(PAT_CHECKER));
		reg_write(REG_SIZE, 32'd2);
		queue_requests(5, 1'b0);
		wait_idle();

		// Random pixels with seed zero; upper bits of the write data are dropped
		reg_write(REG_PATTERN, 32'hFFFF_FFFE);
		queue_requests(3, 1'b1);
		wait_idle();
		reg_write(REG_SEED, 32'hFFFF_FFFF);
		queue_requests(2, 1'b1);
		wait_idle();

		// Oversized image_size clamps to the maximum; seed holds until a frame start
		reg_write(REG_SIZE, 32'hFFFF_FFFF);
		reg_write(REG_SEED, 32'h1234_5678);
		queue_requests(2, 1'b0);
		wait_idle();

		// Gradient over a full 160 line and into the next row
		reg_write(REG_PATTERN, DATA_W'(PAT_GRADIENT));
		reg_write(REG_SIZE, 32'd160);
		queue_requests(163, 1'b1);
		wait_idle();

		// Shrink mid-frame: next position is outside, so a new frame starts
		reg_write(REG_SIZE, 32'd3);
		queue_requests(4, 1'b0);
		wait_idle();

		// Random phases: mostly small images so frames complete; registers change
		// between bursts, often with a frame still open
		rand_items = 0;
		while (rand_items < 340) begin
			if ($urandom_range(99) < 60) begin
				pick = $urandom_range(99);
				reg_write(REG_PATTERN, DATA_W'((pick < 30) ? PAT_GRADIENT :
					(pick < 50) ? PAT_CHECKER : (pick < 85) ? PAT_RANDOM : PAT_BLANK));
			end
			if ($urandom_range(99) < 50) begin
				pick = $urandom_range(99);
				if (pick < 80)
					size_word = $urandom_range(9, 1);
				else if (pick < 90)
					size_word = ($urandom_range(1) == 0) ? 0 : $urandom_range(40, 10);
				else if (pick < 95)
					size_word = $urandom_range(512, 511);
				else
					size_word = {22'($urandom_range(32'h003F_FFFF)),
						10'($urandom_range(1023, 513))};
				reg_write(REG_SIZE, size_word);
			end
			if ($urandom_range(99) < 40)
				reg_write(REG_SEED, ($urandom_range(99) < 20) ? 32'd0 : $urandom());
			burst = $urandom_range(40, 5);
			for (int i = 0; i < burst; i++)
				pend_restart.push_back($urandom_range(99) < 5);
			rand_items += burst;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("Checked %0d pixels, %0d complete frames.", n_checked, n_frames);
		$display("Pixels by pattern: gradient %0d, checker %0d, random %0d, blank %0d.",
			per_pattern[0], per_pattern[1], per_pattern[2], per_pattern[3]);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog, far above the slowest correct run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== raster_test_pattern_generator_core.f =====
sv/rtpg_pkg.sv
sv/rtpg_regs.sv
sv/rtpg_div.sv
sv/rtpg_dpath.sv
sv/rtpg_ctrl.sv
sv/raster_test_pattern_generator_core.sv
dv/raster_test_pattern_generator_core_test.sv
